/* rtl/byte_cpu_core_6502_macros.svh */
// Assertion macros shared by the checker of the 6502 core.
`ifndef BYTE_CPU_CORE_6502_MACROS_SVH
`define BYTE_CPU_CORE_6502_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bcc_pkg.sv */
// Package of the 6502 core: item types, command codes and opcode decode.
`timescale 1ns / 1ps
`default_nettype none
package bcc_pkg;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] read_data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] bus_address;
    logic        is_write;
    logic [7:0]  write_data;
    logic        wants_data;
    logic        last;
    logic        done_res;
    logic [15:0] pc_now;
    logic [7:0]  acc_now;
    logic [7:0]  x_now;
    logic [7:0]  y_now;
    logic [7:0]  sp_now;
    logic [7:0]  status_now;
  } res_t;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_DATA  = 3'd1;
  localparam logic [2:0] MODE_IRQ   = 3'd2;
  localparam logic [2:0] MODE_NMI   = 3'd3;
  localparam logic [2:0] MODE_RESET = 3'd4;

  localparam logic CFG_RESET_FROM_VECTOR = 1'b0;
  localparam logic CFG_START_ADDRESS     = 1'b1;

  localparam logic        RESET_FROM_VECTOR_DEFAULT = 1'b1;
  localparam logic [15:0] START_ADDRESS_DEFAULT     = 16'h0000;

  localparam logic [15:0] VEC_NMI   = 16'hfffa;
  localparam logic [15:0] VEC_RESET = 16'hfffc;
  localparam logic [15:0] VEC_IRQ   = 16'hfffe;
  localparam logic [7:0]  FL_FIXED  = 8'h30;
  localparam logic [7:0]  SP_RESET  = 8'hff;
  localparam logic [7:0]  STACK_HI  = 8'h01;

  typedef enum logic [3:0] {
    AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABX, AM_ABY, AM_IND, AM_INX, AM_INY
  } am_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_ADC, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI,
    OP_BNE, OP_BPL, OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV,
    OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX,
    OP_INY, OP_JMP, OP_JSR, OP_LDA, OP_LDX, OP_LDY, OP_LSR, OP_ORA, OP_PHA,
    OP_PHP, OP_PLA, OP_PLP, OP_ROL, OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC,
    OP_SED, OP_SEI, OP_STA, OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA,
    OP_TXS, OP_TYA
  } op_t;

  typedef struct packed {
    op_t op;
    am_t am;
  } dec_t;

  // Opcode decode; undocumented opcodes become one-byte no-ops.
  function automatic dec_t decode(input logic [7:0] o);
    dec_t r;
    case (o)
      8'h00: r = '{OP_BRK, AM_IMM}; 8'h01: r = '{OP_ORA, AM_INX};
      8'h05: r = '{OP_ORA, AM_ZP};  8'h06: r = '{OP_ASL, AM_ZP};
      8'h08: r = '{OP_PHP, AM_IMP}; 8'h09: r = '{OP_ORA, AM_IMM};
      8'h0A: r = '{OP_ASL, AM_IMP}; 8'h0D: r = '{OP_ORA, AM_ABS};
      8'h0E: r = '{OP_ASL, AM_ABS};
      8'h10: r = '{OP_BPL, AM_IMM}; 8'h11: r = '{OP_ORA, AM_INY};
      8'h15: r = '{OP_ORA, AM_ZPX}; 8'h16: r = '{OP_ASL, AM_ZPX};
      8'h18: r = '{OP_CLC, AM_IMP}; 8'h19: r = '{OP_ORA, AM_ABY};
      8'h1D: r = '{OP_ORA, AM_ABX}; 8'h1E: r = '{OP_ASL, AM_ABX};
      8'h20: r = '{OP_JSR, AM_ABS}; 8'h21: r = '{OP_AND, AM_INX};
      8'h24: r = '{OP_BIT, AM_ZP};  8'h25: r = '{OP_AND, AM_ZP};
      8'h26: r = '{OP_ROL, AM_ZP};  8'h28: r = '{OP_PLP, AM_IMP};
      8'h29: r = '{OP_AND, AM_IMM}; 8'h2A: r = '{OP_ROL, AM_IMP};
      8'h2C: r = '{OP_BIT, AM_ABS}; 8'h2D: r = '{OP_AND, AM_ABS};
      8'h2E: r = '{OP_ROL, AM_ABS};
      8'h30: r = '{OP_BMI, AM_IMM}; 8'h31: r = '{OP_AND, AM_INY};
      8'h35: r = '{OP_AND, AM_ZPX}; 8'h36: r = '{OP_ROL, AM_ZPX};
      8'h38: r = '{OP_SEC, AM_IMP}; 8'h39: r = '{OP_AND, AM_ABY};
      8'h3D: r = '{OP_AND, AM_ABX}; 8'h3E: r = '{OP_ROL, AM_ABX};
      8'h40: r = '{OP_RTI, AM_IMP}; 8'h41: r = '{OP_EOR, AM_INX};
      8'h45: r = '{OP_EOR, AM_ZP};  8'h46: r = '{OP_LSR, AM_ZP};
      8'h48: r = '{OP_PHA, AM_IMP}; 8'h49: r = '{OP_EOR, AM_IMM};
      8'h4A: r = '{OP_LSR, AM_IMP}; 8'h4C: r = '{OP_JMP, AM_ABS};
      8'h4D: r = '{OP_EOR, AM_ABS}; 8'h4E: r = '{OP_LSR, AM_ABS};
      8'h50: r = '{OP_BVC, AM_IMM}; 8'h51: r = '{OP_EOR, AM_INY};
      8'h55: r = '{OP_EOR, AM_ZPX}; 8'h56: r = '{OP_LSR, AM_ZPX};
      8'h58: r = '{OP_CLI, AM_IMP}; 8'h59: r = '{OP_EOR, AM_ABY};
      8'h5D: r = '{OP_EOR, AM_ABX}; 8'h5E: r = '{OP_LSR, AM_ABX};
      8'h60: r = '{OP_RTS, AM_IMP}; 8'h61: r = '{OP_ADC, AM_INX};
      8'h65: r = '{OP_ADC, AM_ZP};  8'h66: r = '{OP_ROR, AM_ZP};
      8'h68: r = '{OP_PLA, AM_IMP}; 8'h69: r = '{OP_ADC, AM_IMM};
      8'h6A: r = '{OP_ROR, AM_IMP}; 8'h6C: r = '{OP_JMP, AM_IND};
      8'h6D: r = '{OP_ADC, AM_ABS}; 8'h6E: r = '{OP_ROR, AM_ABS};
      8'h70: r = '{OP_BVS, AM_IMM}; 8'h71: r = '{OP_ADC, AM_INY};
      8'h75: r = '{OP_ADC, AM_ZPX}; 8'h76: r = '{OP_ROR, AM_ZPX};
      8'h78: r = '{OP_SEI, AM_IMP}; 8'h79: r = '{OP_ADC, AM_ABY};
      8'h7D: r = '{OP_ADC, AM_ABX}; 8'h7E: r = '{OP_ROR, AM_ABX};
      8'h81: r = '{OP_STA, AM_INX}; 8'h84: r = '{OP_STY, AM_ZP};
      8'h85: r = '{OP_STA, AM_ZP};  8'h86: r = '{OP_STX, AM_ZP};
      8'h88: r = '{OP_DEY, AM_IMP}; 8'h8A: r = '{OP_TXA, AM_IMP};
      8'h8C: r = '{OP_STY, AM_ABS}; 8'h8D: r = '{OP_STA, AM_ABS};
      8'h8E: r = '{OP_STX, AM_ABS};
      8'h90: r = '{OP_BCC, AM_IMM}; 8'h91: r = '{OP_STA, AM_INY};
      8'h94: r = '{OP_STY, AM_ZPX}; 8'h95: r = '{OP_STA, AM_ZPX};
      8'h96: r = '{OP_STX, AM_ZPY}; 8'h98: r = '{OP_TYA, AM_IMP};
      8'h99: r = '{OP_STA, AM_ABY}; 8'h9A: r = '{OP_TXS, AM_IMP};
      8'h9D: r = '{OP_STA, AM_ABX};
      8'hA0: r = '{OP_LDY, AM_IMM}; 8'hA1: r = '{OP_LDA, AM_INX};
      8'hA2: r = '{OP_LDX, AM_IMM}; 8'hA4: r = '{OP_LDY, AM_ZP};
      8'hA5: r = '{OP_LDA, AM_ZP};  8'hA6: r = '{OP_LDX, AM_ZP};
      8'hA8: r = '{OP_TAY, AM_IMP}; 8'hA9: r = '{OP_LDA, AM_IMM};
      8'hAA: r = '{OP_TAX, AM_IMP}; 8'hAC: r = '{OP_LDY, AM_ABS};
      8'hAD: r = '{OP_LDA, AM_ABS}; 8'hAE: r = '{OP_LDX, AM_ABS};
      8'hB0: r = '{OP_BCS, AM_IMM}; 8'hB1: r = '{OP_LDA, AM_INY};
      8'hB4: r = '{OP_LDY, AM_ZPX}; 8'hB5: r = '{OP_LDA, AM_ZPX};
      8'hB6: r = '{OP_LDX, AM_ZPY}; 8'hB8: r = '{OP_CLV, AM_IMP};
      8'hB9: r = '{OP_LDA, AM_ABY}; 8'hBA: r = '{OP_TSX, AM_IMP};
      8'hBC: r = '{OP_LDY, AM_ABX}; 8'hBD: r = '{OP_LDA, AM_ABX};
      8'hBE: r = '{OP_LDX, AM_ABY};
      8'hC0: r = '{OP_CPY, AM_IMM}; 8'hC1: r = '{OP_CMP, AM_INX};
      8'hC4: r = '{OP_CPY, AM_ZP};  8'hC5: r = '{OP_CMP, AM_ZP};
      8'hC6: r = '{OP_DEC, AM_ZP};  8'hC8: r = '{OP_INY, AM_IMP};
      8'hC9: r = '{OP_CMP, AM_IMM}; 8'hCA: r = '{OP_DEX, AM_IMP};
      8'hCC: r = '{OP_CPY, AM_ABS}; 8'hCD: r = '{OP_CMP, AM_ABS};
      8'hCE: r = '{OP_DEC, AM_ABS};
      8'hD0: r = '{OP_BNE, AM_IMM}; 8'hD1: r = '{OP_CMP, AM_INY};
      8'hD5: r = '{OP_CMP, AM_ZPX}; 8'hD6: r = '{OP_DEC, AM_ZPX};
      8'hD8: r = '{OP_CLD, AM_IMP}; 8'hD9: r = '{OP_CMP, AM_ABY};
      8'hDD: r = '{OP_CMP, AM_ABX}; 8'hDE: r = '{OP_DEC, AM_ABX};
      8'hE0: r = '{OP_CPX, AM_IMM}; 8'hE1: r = '{OP_SBC, AM_INX};
      8'hE4: r = '{OP_CPX, AM_ZP};  8'hE5: r = '{OP_SBC, AM_ZP};
      8'hE6: r = '{OP_INC, AM_ZP};  8'hE8: r = '{OP_INX, AM_IMP};
      8'hE9: r = '{OP_SBC, AM_IMM}; 8'hEA: r = '{OP_NOP, AM_IMP};
      8'hEC: r = '{OP_CPX, AM_ABS}; 8'hED: r = '{OP_SBC, AM_ABS};
      8'hEE: r = '{OP_INC, AM_ABS};
      8'hF0: r = '{OP_BEQ, AM_IMM}; 8'hF1: r = '{OP_SBC, AM_INY};
      8'hF5: r = '{OP_SBC, AM_ZPX}; 8'hF6: r = '{OP_INC, AM_ZPX};
      8'hF8: r = '{OP_SED, AM_IMP}; 8'hF9: r = '{OP_SBC, AM_ABY};
      8'hFD: r = '{OP_SBC, AM_ABX}; 8'hFE: r = '{OP_INC, AM_ABX};
      default: r = '{OP_NOP, AM_IMP};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/byte_cpu_core_6502.sv */
// Top level of the 6502 instruction-set core driven one bus access at a time.
`timescale 1ns / 1ps
`default_nettype none
// The core runs the documented 6502 instruction set against an outside bus,
// one command item at a time. A command item starts the next instruction,
// returns the byte for the pending read request, raises IRQ or NMI, or resets
// the core. The combinational decode and execute logic works out each
// accepted command, updates the architectural registers and loads the bus
// accesses it causes (up to three writes, then at most one read request) into
// a four-entry run buffer. While res_stall is low, the run buffer drains one
// result item per clock on the result channel, the last one marked, and the
// register snapshot carried by every result is the register state after the
// command. Commands that cause at most one bus access stream back to back; a
// command that causes more holds the result port until its last result is
// taken (four results at most, for BRK and interrupt entry), and the next
// command is taken in the same clock as the last result of the run. ADC and
// SBC are always binary, indirect JMP keeps the page wrap of its pointer, and
// undocumented opcodes are one-byte no-ops. The configuration port selects
// whether a reset command fetches the reset vector or loads the start address
// register; the user must write it only while idle; the core does not check.
module byte_cpu_core_6502 #(
  parameter logic        ResetFromVector = bcc_pkg::RESET_FROM_VECTOR_DEFAULT,
  parameter logic [15:0] StartAddress    = bcc_pkg::START_ADDRESS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_stall,
  input  wire bcc_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_stall,
  output bcc_pkg::res_t      res,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data
);
  import bcc_pkg::*;

  // Sequencer phase between bus responses.
  typedef enum logic [3:0] {
    PH_IDLE, PH_OPC, PH_ZP, PH_ABLO, PH_ABHI, PH_PTRLO, PH_PTRHI, PH_DATA,
    PH_PULL, PH_RTSLO, PH_RTSHI, PH_RTIP, PH_RTILO, PH_RTIHI, PH_VECLO, PH_VECHI
  } phase_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  data;
    logic        wants;
  } bus_t;

  // Architectural and sequencer state.
  logic [15:0] pc, ea;
  logic [7:0]  acc, xr, yr, sp, pf, opc, opnd;
  phase_t      phase;
  logic        rfv;
  logic [15:0] start_addr;

  // Run buffer of bus accesses for the command last taken.
  bus_t       run [4];
  logic [2:0] cnt;
  logic [1:0] pos;
  logic       fin;

  // Next values from the execute logic.
  logic [15:0] pc_next, ea_next;
  logic [7:0]  acc_next, xr_next, yr_next, sp_next, pf_next, opc_next, opnd_next;
  phase_t      phase_next;
  bus_t        run_next [4];
  logic [2:0]  cnt_next;
  logic        fin_next;

  logic accept, res_take, at_last;

  // Shift, rotate, increment or decrement with flag update; returns {flags, value}.
  function automatic logic [15:0] rmw(input op_t op, input logic [7:0] v,
                                      input logic [7:0] p);
    logic [7:0] r;
    logic [7:0] q;
    q = p;
    r = v;
    case (op)
      OP_ASL: begin
        q[0] = v[7];
        r = {v[6:0], 1'b0};
      end
      OP_LSR: begin
        q[0] = v[0];
        r = {1'b0, v[7:1]};
      end
      OP_ROL: begin
        q[0] = v[7];
        r = {v[6:0], p[0]};
      end
      OP_ROR: begin
        q[0] = v[0];
        r = {p[0], v[7:1]};
      end
      OP_INC: r = v + 8'd1;
      OP_DEC: r = v - 8'd1;
      default: r = v;
    endcase
    q[7] = r[7];
    q[1] = (r == 8'h00);
    return {q, r};
  endfunction

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    return {v[7], p[6:2], (v == 8'h00), p[0]};
  endfunction

  always_comb begin
    dec_t        dc;
    logic [7:0]  d;
    logic [7:0]  v8;
    logic [15:0] t16;
    logic [8:0]  sum;
    logic        tk;
    logic        adr_rdy;
    logic        int_go;
    logic [15:0] int_vec;
    logic [7:0]  int_push;

    pc_next    = pc;
    ea_next    = ea;
    acc_next   = acc;
    xr_next    = xr;
    yr_next    = yr;
    sp_next    = sp;
    pf_next    = pf;
    opc_next   = opc;
    opnd_next  = opnd;
    phase_next = phase;
    for (int i = 0; i < 4; i++) run_next[i] = '0;
    cnt_next = 3'd0;
    fin_next = 1'b0;
    adr_rdy  = 1'b0;
    int_go   = 1'b0;
    int_vec  = VEC_IRQ;
    int_push = 8'h00;
    d        = cmd.read_data;
    v8       = 8'h00;
    t16      = 16'h0000;
    sum      = 9'h000;
    tk       = 1'b0;
    dc       = decode((phase == PH_OPC) ? d : opc);

    case (cmd.mode)
      MODE_START: begin
        if (phase == PH_IDLE) begin
          run_next[0] = '{pc, 1'b0, 8'h00, 1'b1};
          cnt_next    = 3'd1;
          phase_next  = PH_OPC;
          pc_next     = pc + 16'd1;
        end
      end
      MODE_IRQ: begin
        if (phase == PH_IDLE && !pf[2]) begin
          int_go   = 1'b1;
          int_vec  = VEC_IRQ;
          int_push = (pf | FL_FIXED) & 8'hef;
        end
      end
      MODE_NMI: begin
        if (phase == PH_IDLE) begin
          int_go   = 1'b1;
          int_vec  = VEC_NMI;
          int_push = (pf | FL_FIXED) & 8'hef;
        end
      end
      MODE_RESET: begin
        acc_next  = 8'h00;
        xr_next   = 8'h00;
        yr_next   = 8'h00;
        sp_next   = SP_RESET;
        pf_next   = FL_FIXED;
        opc_next  = 8'h00;
        opnd_next = 8'h00;
        ea_next   = 16'h0000;
        if (rfv) begin
          ea_next     = VEC_RESET;
          run_next[0] = '{VEC_RESET, 1'b0, 8'h00, 1'b1};
          cnt_next    = 3'd1;
          phase_next  = PH_VECLO;
        end else begin
          pc_next  = start_addr;
          fin_next = 1'b1;
        end
      end
      MODE_DATA: begin
        case (phase)
          PH_IDLE: ;
          PH_OPC: begin
            opc_next = d;
            if (dc.am == AM_IMP) begin
              case (dc.op)
                OP_TAX: begin xr_next = acc; pf_next = set_nz(pf, acc); end
                OP_TAY: begin yr_next = acc; pf_next = set_nz(pf, acc); end
                OP_TXA: begin acc_next = xr; pf_next = set_nz(pf, xr); end
                OP_TYA: begin acc_next = yr; pf_next = set_nz(pf, yr); end
                OP_TSX: begin xr_next = sp; pf_next = set_nz(pf, sp); end
                OP_TXS: sp_next = xr;
                OP_INX: begin
                  xr_next = xr + 8'd1;
                  pf_next = set_nz(pf, xr_next);
                end
                OP_INY: begin
                  yr_next = yr + 8'd1;
                  pf_next = set_nz(pf, yr_next);
                end
                OP_DEX: begin
                  xr_next = xr - 8'd1;
                  pf_next = set_nz(pf, xr_next);
                end
                OP_DEY: begin
                  yr_next = yr - 8'd1;
                  pf_next = set_nz(pf, yr_next);
                end
                OP_CLC: pf_next[0] = 1'b0;
                OP_SEC: pf_next[0] = 1'b1;
                OP_CLI: pf_next[2] = 1'b0;
                OP_SEI: pf_next[2] = 1'b1;
                OP_CLV: pf_next[6] = 1'b0;
                OP_CLD: pf_next[3] = 1'b0;
                OP_SED: pf_next[3] = 1'b1;
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: {pf_next, acc_next} = rmw(dc.op, acc, pf);
                OP_PHA: begin
                  run_next[0] = '{{STACK_HI, sp}, 1'b1, acc, 1'b0};
                  cnt_next    = 3'd1;
                  sp_next     = sp - 8'd1;
                end
                OP_PHP: begin
                  run_next[0] = '{{STACK_HI, sp}, 1'b1, pf | FL_FIXED, 1'b0};
                  cnt_next    = 3'd1;
                  sp_next     = sp - 8'd1;
                end
                default: ;
              endcase
              if (dc.op == OP_PLA || dc.op == OP_PLP || dc.op == OP_RTS ||
                  dc.op == OP_RTI) begin
                sp_next     = sp + 8'd1;
                run_next[0] = '{{STACK_HI, sp_next}, 1'b0, 8'h00, 1'b1};
                cnt_next    = 3'd1;
                case (dc.op)
                  OP_RTS:  phase_next = PH_RTSLO;
                  OP_RTI:  phase_next = PH_RTIP;
                  default: phase_next = PH_PULL;
                endcase
              end else begin
                fin_next = 1'b1;
              end
            end else if (dc.am == AM_IMM) begin
              ea_next     = pc;
              pc_next     = pc + 16'd1;
              run_next[0] = '{pc, 1'b0, 8'h00, 1'b1};
              cnt_next    = 3'd1;
              phase_next  = PH_DATA;
            end else begin
              run_next[0] = '{pc, 1'b0, 8'h00, 1'b1};
              cnt_next    = 3'd1;
              pc_next     = pc + 16'd1;
              if (dc.am == AM_ABS || dc.am == AM_ABX || dc.am == AM_ABY ||
                  dc.am == AM_IND) begin
                phase_next = PH_ABLO;
              end else begin
                phase_next = PH_ZP;
              end
            end
          end
          PH_ZP: begin
            if (dc.am == AM_ZPX || dc.am == AM_INX) ea_next = {8'h00, d + xr};
            else if (dc.am == AM_ZPY) ea_next = {8'h00, d + yr};
            else ea_next = {8'h00, d};
            if (dc.am == AM_INX || dc.am == AM_INY) begin
              run_next[0] = '{ea_next, 1'b0, 8'h00, 1'b1};
              cnt_next    = 3'd1;
              phase_next  = PH_PTRLO;
            end else begin
              adr_rdy = 1'b1;
            end
          end
          PH_ABLO: begin
            opnd_next   = d;
            run_next[0] = '{pc, 1'b0, 8'h00, 1'b1};
            cnt_next    = 3'd1;
            phase_next  = PH_ABHI;
            pc_next     = pc + 16'd1;
          end
          PH_ABHI: begin
            t16 = {d, opnd};
            if (dc.am == AM_IND) begin
              ea_next     = t16;
              run_next[0] = '{t16, 1'b0, 8'h00, 1'b1};
              cnt_next    = 3'd1;
              phase_next  = PH_PTRLO;
            end else begin
              if (dc.am == AM_ABX) ea_next = t16 + {8'h00, xr};
              else if (dc.am == AM_ABY) ea_next = t16 + {8'h00, yr};
              else ea_next = t16;
              adr_rdy = 1'b1;
            end
          end
          PH_PTRLO: begin
            // The pointer high byte is read from the same page.
            opnd_next   = d;
            run_next[0] = '{{ea[15:8], ea[7:0] + 8'd1}, 1'b0, 8'h00, 1'b1};
            cnt_next    = 3'd1;
            phase_next  = PH_PTRHI;
          end
          PH_PTRHI: begin
            t16 = {d, opnd};
            if (dc.am == AM_INY) ea_next = t16 + {8'h00, yr};
            else ea_next = t16;
            adr_rdy = 1'b1;
          end
          PH_DATA: begin
            fin_next = 1'b1;
            case (dc.op)
              OP_LDA: begin acc_next = d; pf_next = set_nz(pf, d); end
              OP_LDX: begin xr_next = d; pf_next = set_nz(pf, d); end
              OP_LDY: begin yr_next = d; pf_next = set_nz(pf, d); end
              OP_AND: begin acc_next = acc & d; pf_next = set_nz(pf, acc & d); end
              OP_ORA: begin acc_next = acc | d; pf_next = set_nz(pf, acc | d); end
              OP_EOR: begin acc_next = acc ^ d; pf_next = set_nz(pf, acc ^ d); end
              OP_ADC, OP_SBC: begin
                v8  = (dc.op == OP_SBC) ? ~d : d;
                sum = {1'b0, acc} + {1'b0, v8} + {8'h00, pf[0]};
                acc_next   = sum[7:0];
                pf_next    = set_nz(pf, sum[7:0]);
                pf_next[0] = sum[8];
                pf_next[6] = (acc[7] ^ sum[7]) & (v8[7] ^ sum[7]);
              end
              OP_CMP, OP_CPX, OP_CPY: begin
                case (dc.op)
                  OP_CPX:  v8 = xr;
                  OP_CPY:  v8 = yr;
                  default: v8 = acc;
                endcase
                pf_next    = set_nz(pf, v8 - d);
                pf_next[0] = (v8 >= d);
              end
              OP_BIT: begin
                pf_next[1] = ((acc & d) == 8'h00);
                pf_next[6] = d[6];
                pf_next[7] = d[7];
              end
              OP_BCC, OP_BCS, OP_BNE, OP_BEQ, OP_BPL, OP_BMI, OP_BVC, OP_BVS: begin
                case (dc.op)
                  OP_BCC:  tk = !pf[0];
                  OP_BCS:  tk = pf[0];
                  OP_BNE:  tk = !pf[1];
                  OP_BEQ:  tk = pf[1];
                  OP_BPL:  tk = !pf[7];
                  OP_BMI:  tk = pf[7];
                  OP_BVC:  tk = !pf[6];
                  default: tk = pf[6];
                endcase
                if (tk) pc_next = pc + {{8{d[7]}}, d};
              end
              OP_BRK: begin
                fin_next = 1'b0;
                int_go   = 1'b1;
                int_vec  = VEC_IRQ;
                int_push = pf | FL_FIXED;
              end
              OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
                {pf_next, v8} = rmw(dc.op, d, pf);
                run_next[0]   = '{ea, 1'b1, v8, 1'b0};
                cnt_next      = 3'd1;
              end
              default: ;
            endcase
          end
          PH_PULL: begin
            if (dc.op == OP_PLA) begin
              acc_next = d;
              pf_next  = set_nz(pf, d);
            end else begin
              pf_next = d | FL_FIXED;
            end
            fin_next = 1'b1;
          end
          PH_RTSLO, PH_RTIP, PH_RTILO: begin
            if (phase == PH_RTIP) pf_next = d | FL_FIXED;
            else opnd_next = d;
            sp_next     = sp + 8'd1;
            run_next[0] = '{{STACK_HI, sp_next}, 1'b0, 8'h00, 1'b1};
            cnt_next    = 3'd1;
            case (phase)
              PH_RTSLO: phase_next = PH_RTSHI;
              PH_RTIP:  phase_next = PH_RTILO;
              default:  phase_next = PH_RTIHI;
            endcase
          end
          PH_RTSHI: begin
            pc_next  = {d, opnd} + 16'd1;
            fin_next = 1'b1;
          end
          PH_RTIHI, PH_VECHI: begin
            pc_next  = {d, opnd};
            fin_next = 1'b1;
          end
          PH_VECLO: begin
            opnd_next   = d;
            run_next[0] = '{ea + 16'd1, 1'b0, 8'h00, 1'b1};
            cnt_next    = 3'd1;
            phase_next  = PH_VECHI;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      default: ;
    endcase

    // Effective address known: store, jump, subroutine call or data read.
    if (adr_rdy) begin
      case (dc.op)
        OP_STA, OP_STX, OP_STY: begin
          case (dc.op)
            OP_STX:  v8 = xr;
            OP_STY:  v8 = yr;
            default: v8 = acc;
          endcase
          run_next[0] = '{ea_next, 1'b1, v8, 1'b0};
          cnt_next    = 3'd1;
          fin_next    = 1'b1;
        end
        OP_JMP: begin
          pc_next  = ea_next;
          fin_next = 1'b1;
        end
        OP_JSR: begin
          t16         = pc - 16'd1;
          run_next[0] = '{{STACK_HI, sp}, 1'b1, t16[15:8], 1'b0};
          run_next[1] = '{{STACK_HI, sp - 8'd1}, 1'b1, t16[7:0], 1'b0};
          cnt_next    = 3'd2;
          sp_next     = sp - 8'd2;
          pc_next     = ea_next;
          fin_next    = 1'b1;
        end
        default: begin
          run_next[0] = '{ea_next, 1'b0, 8'h00, 1'b1};
          cnt_next    = 3'd1;
          phase_next  = PH_DATA;
        end
      endcase
    end

    // Interrupt entry: push PC and flags, set I, then fetch the vector.
    if (int_go) begin
      run_next[0] = '{{STACK_HI, sp}, 1'b1, pc_next[15:8], 1'b0};
      run_next[1] = '{{STACK_HI, sp - 8'd1}, 1'b1, pc_next[7:0], 1'b0};
      run_next[2] = '{{STACK_HI, sp - 8'd2}, 1'b1, int_push, 1'b0};
      run_next[3] = '{int_vec, 1'b0, 8'h00, 1'b1};
      cnt_next    = 3'd4;
      sp_next     = sp - 8'd3;
      pf_next     = pf_next | 8'h04;
      ea_next     = int_vec;
      phase_next  = PH_VECLO;
    end

    if (fin_next) begin
      phase_next = PH_IDLE;
      // A finished sequence with no access still reports once.
      if (cnt_next == 3'd0) cnt_next = 3'd1;
    end
  end

  assign res_valid = (cnt != 3'd0);
  assign at_last   = ({1'b0, pos} == cnt - 3'd1);
  assign res_take  = res_valid && !res_stall;
  assign cmd_stall = res_valid && !(res_take && at_last);
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    res             = '0;
    res.bus_address = run[pos].addr;
    res.is_write    = run[pos].wr;
    res.write_data  = run[pos].data;
    res.wants_data  = run[pos].wants;
    res.last        = at_last;
    res.done_res    = at_last && fin;
    res.pc_now      = pc;
    res.acc_now     = acc;
    res.x_now       = xr;
    res.y_now       = yr;
    res.sp_now      = sp;
    res.status_now  = pf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= StartAddress;
      ea         <= 16'h0000;
      acc        <= 8'h00;
      xr         <= 8'h00;
      yr         <= 8'h00;
      sp         <= SP_RESET;
      pf         <= FL_FIXED;
      opc        <= 8'h00;
      opnd       <= 8'h00;
      phase      <= PH_IDLE;
      rfv        <= ResetFromVector;
      start_addr <= StartAddress;
      cnt        <= 3'd0;
      pos        <= 2'd0;
      fin        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RESET_FROM_VECTOR: rfv <= cfg_data[0];
          default:               start_addr <= cfg_data;
        endcase
      end
      if (accept) begin
        pc    <= pc_next;
        ea    <= ea_next;
        acc   <= acc_next;
        xr    <= xr_next;
        yr    <= yr_next;
        sp    <= sp_next;
        pf    <= pf_next;
        opc   <= opc_next;
        opnd  <= opnd_next;
        phase <= phase_next;
        run   <= run_next;
        cnt   <= cnt_next;
        pos   <= 2'd0;
        fin   <= fin_next;
      end else if (res_take) begin
        if (at_last) cnt <= 3'd0;
        else pos <= pos + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/bcc_checker.sv */
// Port checker of the 6502 core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_cpu_core_6502_macros.svh"
module bcc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          cmd_stall,
  input wire logic          res_valid,
  input wire logic          res_stall,
  input wire bcc_pkg::res_t res
);
  import bcc_pkg::*;

  // A result waiting on a stall keeps its value.
  `BCC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
  // Only the final result of a run may close a sequence.
  `BCC_ASSERT_NOW(a_done_last, res_valid && res.done_res, res.last, "done_res on a non-final result")
  // A read request always ends its run.
  `BCC_ASSERT_NOW(a_read_last, res_valid && res.wants_data, res.last, "read request not final")
  // No new command is taken while a run still has results after this one.
  `BCC_ASSERT_NOW(a_busy_stall, res_valid && !res.last, cmd_stall, "command taken mid-run")
  // A taken result that is not final is followed by another one.
  `BCC_ASSERT_NEXT(a_run_cont, res_valid && !res.last && !res_stall, res_valid, "run ended early")

endmodule

bind byte_cpu_core_6502 bcc_checker u_bcc_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
`default_nettype wire

/* test/tb_byte_cpu_core_6502.sv */
// Self-checking testbench of the 6502 core with its own predictor and bus model.
`timescale 1ns / 1ps
`default_nettype none
// The testbench plays the outside bus of the core. It starts instructions,
// answers every read request with a byte, and now and then raises IRQ, NMI
// or reset. An internal predictor of the core works out, for every accepted
// command item, the bus accesses and the register snapshot the core must
// return. A checker process compares each accepted result item, field by
// field, with the oldest predicted one. Both channels idle in random bursts
// except near the end of the run.
module tb_byte_cpu_core_6502;
  import bcc_pkg::*;

  localparam int CMD_TARGET = 500;
  localparam int CYCLE_LIMIT = 400000;

  // Sequencer phases of the predicted core.
  typedef enum logic [3:0] {
    P_IDLE, P_OPC, P_ZP, P_ABLO, P_ABHI, P_PTRLO, P_PTRHI, P_DATA,
    P_PULL, P_RTSLO, P_RTSHI, P_RTIP, P_RTILO, P_RTIHI, P_VECLO, P_VECHI
  } seq_phase_t;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_t        cmd;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  byte_cpu_core_6502 dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predicted architectural state and configuration.
  logic        pr_vec_sel;
  logic [15:0] pr_start;
  logic [15:0] pr_pc;
  logic [7:0]  pr_a, pr_x, pr_y, pr_sp, pr_psr, pr_opc, pr_opd;
  logic [15:0] pr_ea;
  seq_phase_t  pr_ph;

  // Accesses caused by the command item being predicted.
  res_t run_buf[4];
  int   run_n;
  bit   seq_done;

  res_t   bus_expect_q[$];
  logic [7:0] script_q[$];
  int     errors;
  int     cmd_count;
  int     cycles;
  bit     quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Watchdog against a hung handshake.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- decode

  function automatic void decode_opcode(input logic [7:0] o, output op_t op, output am_t am);
    logic [2:0] aaa, bbb;
    aaa = o[7:5];
    bbb = o[4:2];
    op = OP_NOP;
    am = AM_IMP;
    case (o[1:0])
      2'b01: begin
        case (aaa)
          3'd0: op = OP_ORA; 3'd1: op = OP_AND; 3'd2: op = OP_EOR; 3'd3: op = OP_ADC;
          3'd4: op = OP_STA; 3'd5: op = OP_LDA; 3'd6: op = OP_CMP; default: op = OP_SBC;
        endcase
        case (bbb)
          3'd0: am = AM_INX; 3'd1: am = AM_ZP;  3'd2: am = AM_IMM; 3'd3: am = AM_ABS;
          3'd4: am = AM_INY; 3'd5: am = AM_ZPX; 3'd6: am = AM_ABY; default: am = AM_ABX;
        endcase
        // STA immediate does not exist.
        if (o == 8'h89) begin
          op = OP_NOP;
          am = AM_IMP;
        end
      end
      2'b10: begin
        case (aaa)
          3'd0: op = OP_ASL; 3'd1: op = OP_ROL; 3'd2: op = OP_LSR; 3'd3: op = OP_ROR;
          3'd4: op = OP_STX; 3'd5: op = OP_LDX; 3'd6: op = OP_DEC; default: op = OP_INC;
        endcase
        case (bbb)
          3'd1: am = AM_ZP;
          3'd3: am = AM_ABS;
          3'd5: am = (aaa == 3'd4 || aaa == 3'd5) ? AM_ZPY : AM_ZPX;
          3'd7: begin
            am = (aaa == 3'd5) ? AM_ABY : AM_ABX;
            if (aaa == 3'd4) begin
              op = OP_NOP;
              am = AM_IMP;
            end
          end
          3'd0: begin
            if (o == 8'hA2) am = AM_IMM;
            else op = OP_NOP;
          end
          3'd2: begin
            case (aaa)
              3'd4: op = OP_TXA; 3'd5: op = OP_TAX; 3'd6: op = OP_DEX; 3'd7: op = OP_NOP;
              default: ;
            endcase
          end
          3'd6: begin
            if (o == 8'h9A) op = OP_TXS;
            else if (o == 8'hBA) op = OP_TSX;
            else op = OP_NOP;
          end
          default: op = OP_NOP;
        endcase
      end
      2'b00: begin
        case (o)
          8'h00: begin op = OP_BRK; am = AM_IMM; end
          8'h08: op = OP_PHP;
          8'h10: begin op = OP_BPL; am = AM_IMM; end
          8'h18: op = OP_CLC;
          8'h20: begin op = OP_JSR; am = AM_ABS; end
          8'h24: begin op = OP_BIT; am = AM_ZP; end
          8'h28: op = OP_PLP;
          8'h2C: begin op = OP_BIT; am = AM_ABS; end
          8'h30: begin op = OP_BMI; am = AM_IMM; end
          8'h38: op = OP_SEC;
          8'h40: op = OP_RTI;
          8'h48: op = OP_PHA;
          8'h4C: begin op = OP_JMP; am = AM_ABS; end
          8'h50: begin op = OP_BVC; am = AM_IMM; end
          8'h58: op = OP_CLI;
          8'h60: op = OP_RTS;
          8'h68: op = OP_PLA;
          8'h6C: begin op = OP_JMP; am = AM_IND; end
          8'h70: begin op = OP_BVS; am = AM_IMM; end
          8'h78: op = OP_SEI;
          8'h84: begin op = OP_STY; am = AM_ZP; end
          8'h88: op = OP_DEY;
          8'h8C: begin op = OP_STY; am = AM_ABS; end
          8'h90: begin op = OP_BCC; am = AM_IMM; end
          8'h94: begin op = OP_STY; am = AM_ZPX; end
          8'h98: op = OP_TYA;
          8'hA0: begin op = OP_LDY; am = AM_IMM; end
          8'hA4: begin op = OP_LDY; am = AM_ZP; end
          8'hA8: op = OP_TAY;
          8'hAC: begin op = OP_LDY; am = AM_ABS; end
          8'hB0: begin op = OP_BCS; am = AM_IMM; end
          8'hB4: begin op = OP_LDY; am = AM_ZPX; end
          8'hB8: op = OP_CLV;
          8'hBC: begin op = OP_LDY; am = AM_ABX; end
          8'hC0: begin op = OP_CPY; am = AM_IMM; end
          8'hC4: begin op = OP_CPY; am = AM_ZP; end
          8'hC8: op = OP_INY;
          8'hCC: begin op = OP_CPY; am = AM_ABS; end
          8'hD0: begin op = OP_BNE; am = AM_IMM; end
          8'hD8: op = OP_CLD;
          8'hE0: begin op = OP_CPX; am = AM_IMM; end
          8'hE4: begin op = OP_CPX; am = AM_ZP; end
          8'hE8: op = OP_INX;
          8'hEC: begin op = OP_CPX; am = AM_ABS; end
          8'hF0: begin op = OP_BEQ; am = AM_IMM; end
          8'hF8: op = OP_SED;
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------- predictor

  function automatic void emit_access(logic [15:0] a, logic w, logic [7:0] d, logic rd);
    if (run_n < 4) begin
      run_buf[run_n] = '0;
      run_buf[run_n].bus_address = a;
      run_buf[run_n].is_write = w;
      run_buf[run_n].write_data = d;
      run_buf[run_n].wants_data = rd;
      run_n++;
    end
  endfunction

  function automatic void read_req(logic [15:0] a, seq_phase_t p);
    emit_access(a, 1'b0, 8'h00, 1'b1);
    pr_ph = p;
  endfunction

  function automatic void end_seq();
    pr_ph = P_IDLE;
    seq_done = 1'b1;
  endfunction

  function automatic void push_byte(logic [7:0] v);
    emit_access({STACK_HI, pr_sp}, 1'b1, v, 1'b0);
    pr_sp = pr_sp - 8'd1;
  endfunction

  function automatic void pull_req(seq_phase_t p);
    pr_sp = pr_sp + 8'd1;
    read_req({STACK_HI, pr_sp}, p);
  endfunction

  function automatic logic [7:0] set_nz(logic [7:0] v);
    pr_psr[1] = (v == 8'h00);
    pr_psr[7] = v[7];
    return v;
  endfunction

  function automatic void enter_irq(logic [15:0] vec, logic [7:0] pushed);
    push_byte(pr_pc[15:8]);
    push_byte(pr_pc[7:0]);
    push_byte(pushed);
    pr_psr[2] = 1'b1;
    pr_ea = vec;
    read_req(vec, P_VECLO);
  endfunction

  // Binary add with carry; decimal mode has no effect.
  function automatic void add_carry(logic [7:0] d);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, pr_a} + {1'b0, d} + {8'h00, pr_psr[0]};
    r = sum[7:0];
    pr_psr[0] = sum[8];
    pr_psr[6] = (pr_a[7] ^ r[7]) & (d[7] ^ r[7]);
    pr_a = set_nz(r);
  endfunction

  function automatic void compare_reg(logic [7:0] r, logic [7:0] d);
    pr_psr[0] = (r >= d);
    void'(set_nz(r - d));
  endfunction

  function automatic logic [7:0] shift_step(op_t op, logic [7:0] v);
    logic c;
    logic [7:0] r;
    c = pr_psr[0];
    r = v;
    case (op)
      OP_ASL: begin pr_psr[0] = v[7]; r = {v[6:0], 1'b0}; end
      OP_LSR: begin pr_psr[0] = v[0]; r = {1'b0, v[7:1]}; end
      OP_ROL: begin pr_psr[0] = v[7]; r = {v[6:0], c}; end
      OP_ROR: begin pr_psr[0] = v[0]; r = {c, v[7:1]}; end
      OP_INC: r = v + 8'd1;
      OP_DEC: r = v - 8'd1;
      default: ;
    endcase
    return set_nz(r);
  endfunction

  function automatic void run_implied(op_t op);
    case (op)
      OP_TAX: pr_x = set_nz(pr_a);
      OP_TAY: pr_y = set_nz(pr_a);
      OP_TXA: pr_a = set_nz(pr_x);
      OP_TYA: pr_a = set_nz(pr_y);
      OP_TSX: pr_x = set_nz(pr_sp);
      OP_TXS: pr_sp = pr_x;
      OP_INX: pr_x = set_nz(pr_x + 8'd1);
      OP_INY: pr_y = set_nz(pr_y + 8'd1);
      OP_DEX: pr_x = set_nz(pr_x - 8'd1);
      OP_DEY: pr_y = set_nz(pr_y - 8'd1);
      OP_CLC: pr_psr[0] = 1'b0;
      OP_SEC: pr_psr[0] = 1'b1;
      OP_CLI: pr_psr[2] = 1'b0;
      OP_SEI: pr_psr[2] = 1'b1;
      OP_CLV: pr_psr[6] = 1'b0;
      OP_CLD: pr_psr[3] = 1'b0;
      OP_SED: pr_psr[3] = 1'b1;
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: pr_a = shift_step(op, pr_a);
      OP_PHA: push_byte(pr_a);
      OP_PHP: push_byte(pr_psr | FL_FIXED);
      OP_PLA, OP_PLP: begin pull_req(P_PULL); return; end
      OP_RTS: begin pull_req(P_RTSLO); return; end
      OP_RTI: begin pull_req(P_RTIP); return; end
      default: ;
    endcase
    end_seq();
  endfunction

  function automatic void address_known(op_t op);
    logic [15:0] ret;
    case (op)
      OP_STA: begin emit_access(pr_ea, 1'b1, pr_a, 1'b0); end_seq(); end
      OP_STX: begin emit_access(pr_ea, 1'b1, pr_x, 1'b0); end_seq(); end
      OP_STY: begin emit_access(pr_ea, 1'b1, pr_y, 1'b0); end_seq(); end
      OP_JMP: begin pr_pc = pr_ea; end_seq(); end
      OP_JSR: begin
        ret = pr_pc - 16'd1;
        push_byte(ret[15:8]);
        push_byte(ret[7:0]);
        pr_pc = pr_ea;
        end_seq();
      end
      default: read_req(pr_ea, P_DATA);
    endcase
  endfunction

  function automatic void take_branch(logic taken, logic [7:0] d);
    if (taken) pr_pc = pr_pc + {{8{d[7]}}, d};
    end_seq();
  endfunction

  function automatic void run_data(op_t op, logic [7:0] d);
    case (op)
      OP_LDA: pr_a = set_nz(d);
      OP_LDX: pr_x = set_nz(d);
      OP_LDY: pr_y = set_nz(d);
      OP_AND: pr_a = set_nz(pr_a & d);
      OP_ORA: pr_a = set_nz(pr_a | d);
      OP_EOR: pr_a = set_nz(pr_a ^ d);
      OP_ADC: add_carry(d);
      OP_SBC: add_carry(~d);
      OP_CMP: compare_reg(pr_a, d);
      OP_CPX: compare_reg(pr_x, d);
      OP_CPY: compare_reg(pr_y, d);
      OP_BIT: begin
        pr_psr[1] = ((pr_a & d) == 8'h00);
        pr_psr[6] = d[6];
        pr_psr[7] = d[7];
      end
      OP_BCC: begin take_branch(!pr_psr[0], d); return; end
      OP_BCS: begin take_branch(pr_psr[0], d); return; end
      OP_BNE: begin take_branch(!pr_psr[1], d); return; end
      OP_BEQ: begin take_branch(pr_psr[1], d); return; end
      OP_BPL: begin take_branch(!pr_psr[7], d); return; end
      OP_BMI: begin take_branch(pr_psr[7], d); return; end
      OP_BVC: begin take_branch(!pr_psr[6], d); return; end
      OP_BVS: begin take_branch(pr_psr[6], d); return; end
      OP_BRK: begin enter_irq(VEC_IRQ, pr_psr | FL_FIXED); return; end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC:
        emit_access(pr_ea, 1'b1, shift_step(op, d), 1'b0);
      default: ;
    endcase
    end_seq();
  endfunction

  function automatic void take_byte(logic [7:0] d);
    op_t op;
    am_t am;
    logic [15:0] a;
    decode_opcode(pr_opc, op, am);
    case (pr_ph)
      P_OPC: begin
        pr_opc = d;
        decode_opcode(pr_opc, op, am);
        if (am == AM_IMP) run_implied(op);
        else if (am == AM_IMM) begin
          pr_ea = pr_pc;
          pr_pc = pr_pc + 16'd1;
          read_req(pr_ea, P_DATA);
        end else begin
          if (am == AM_ABS || am == AM_ABX || am == AM_ABY || am == AM_IND)
            read_req(pr_pc, P_ABLO);
          else
            read_req(pr_pc, P_ZP);
          pr_pc = pr_pc + 16'd1;
        end
      end
      P_ZP: begin
        // Indexed page-zero addresses wrap inside page zero.
        if (am == AM_ZPX || am == AM_INX) pr_ea = {8'h00, d + pr_x};
        else if (am == AM_ZPY) pr_ea = {8'h00, d + pr_y};
        else pr_ea = {8'h00, d};
        if (am == AM_INX || am == AM_INY) read_req(pr_ea, P_PTRLO);
        else address_known(op);
      end
      P_ABLO: begin
        pr_opd = d;
        read_req(pr_pc, P_ABHI);
        pr_pc = pr_pc + 16'd1;
      end
      P_ABHI: begin
        a = {d, pr_opd};
        if (am == AM_IND) begin
          pr_ea = a;
          read_req(a, P_PTRLO);
        end else begin
          if (am == AM_ABX) a = a + {8'h00, pr_x};
          else if (am == AM_ABY) a = a + {8'h00, pr_y};
          pr_ea = a;
          address_known(op);
        end
      end
      P_PTRLO: begin
        // The pointer high byte is read without a carry into the page.
        pr_opd = d;
        read_req({pr_ea[15:8], pr_ea[7:0] + 8'd1}, P_PTRHI);
      end
      P_PTRHI: begin
        a = {d, pr_opd};
        if (am == AM_INY) a = a + {8'h00, pr_y};
        pr_ea = a;
        address_known(op);
      end
      P_DATA: run_data(op, d);
      P_PULL: begin
        if (op == OP_PLA) pr_a = set_nz(d);
        else pr_psr = d | FL_FIXED;
        end_seq();
      end
      P_RTSLO: begin pr_opd = d; pull_req(P_RTSHI); end
      P_RTSHI: begin pr_pc = {d, pr_opd} + 16'd1; end_seq(); end
      P_RTIP: begin pr_psr = d | FL_FIXED; pull_req(P_RTILO); end
      P_RTILO: begin pr_opd = d; pull_req(P_RTIHI); end
      P_RTIHI, P_VECHI: begin pr_pc = {d, pr_opd}; end_seq(); end
      P_VECLO: begin pr_opd = d; read_req(pr_ea + 16'd1, P_VECHI); end
      default: pr_ph = P_IDLE;
    endcase
  endfunction

  function automatic void clear_regs();
    pr_a = 8'h00; pr_x = 8'h00; pr_y = 8'h00;
    pr_sp = SP_RESET; pr_psr = FL_FIXED;
    pr_opc = 8'h00; pr_opd = 8'h00; pr_ea = 16'h0000;
    pr_ph = P_IDLE;
  endfunction

  // Work out the result items of one accepted command and queue them.
  function automatic void predict_cmd(cmd_t c);
    run_n = 0;
    seq_done = 1'b0;
    case (c.mode)
      MODE_START: if (pr_ph == P_IDLE) begin
        read_req(pr_pc, P_OPC);
        pr_pc = pr_pc + 16'd1;
      end
      MODE_DATA: if (pr_ph != P_IDLE) take_byte(c.read_data);
      MODE_IRQ: if (pr_ph == P_IDLE && !pr_psr[2])
        enter_irq(VEC_IRQ, (pr_psr | FL_FIXED) & 8'hEF);
      MODE_NMI: if (pr_ph == P_IDLE) enter_irq(VEC_NMI, (pr_psr | FL_FIXED) & 8'hEF);
      MODE_RESET: begin
        clear_regs();
        if (pr_vec_sel) begin
          pr_ea = VEC_RESET;
          read_req(VEC_RESET, P_VECLO);
        end else begin
          pr_pc = pr_start;
          end_seq();
        end
      end
      default: ;
    endcase
    // A sequence that ends without any access still reports its end.
    if (seq_done && run_n == 0) emit_access(16'h0000, 1'b0, 8'h00, 1'b0);
    for (int k = 0; k < run_n; k++) begin
      run_buf[k].last = (k == run_n - 1);
      run_buf[k].done_res = (k == run_n - 1) && seq_done;
      run_buf[k].pc_now = pr_pc;
      run_buf[k].acc_now = pr_a;
      run_buf[k].x_now = pr_x;
      run_buf[k].y_now = pr_y;
      run_buf[k].sp_now = pr_sp;
      run_buf[k].status_now = pr_psr;
      bus_expect_q.push_back(run_buf[k]);
    end
  endfunction

  // --------------------------------------------------------------- checker

  task automatic check_field(string fname, logic [15:0] e, logic [15:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (bus_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, res);
        errors++;
      end else begin
        res_t e;
        e = bus_expect_q.pop_front();
        check_field("bus_address", e.bus_address, res.bus_address);
        check_field("is_write", 16'(e.is_write), 16'(res.is_write));
        check_field("write_data", 16'(e.write_data), 16'(res.write_data));
        check_field("wants_data", 16'(e.wants_data), 16'(res.wants_data));
        check_field("last", 16'(e.last), 16'(res.last));
        check_field("done_res", 16'(e.done_res), 16'(res.done_res));
        check_field("pc_now", e.pc_now, res.pc_now);
        check_field("acc_now", 16'(e.acc_now), 16'(res.acc_now));
        check_field("x_now", 16'(e.x_now), 16'(res.x_now));
        check_field("y_now", 16'(e.y_now), 16'(res.y_now));
        check_field("sp_now", 16'(e.sp_now), 16'(res.sp_now));
        check_field("status_now", 16'(e.status_now), 16'(res.status_now));
      end
    end
  end

  // Result-side stalls come in bursts; none once the run is winding down.
  initial begin
    res_stall = 1'b0;
    forever begin
      res_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // ----------------------------------------------------------- bus driving

  // Send one command item; the predictor runs at the edge that accepts it.
  task automatic issue_cmd(logic [2:0] m, logic [7:0] d);
    cmd_t c;
    c.mode = m;
    c.read_data = d;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    predict_cmd(c);
    cmd_count++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // A scripted byte if one is waiting, else a random opcode or data byte.
  function automatic logic [7:0] next_byte();
    logic [7:0] o;
    op_t op;
    am_t am;
    if (script_q.size() > 0) return script_q.pop_front();
    o = 8'($urandom_range(0, 255));
    // Mostly documented opcodes, so that deep sequences get exercised.
    if (pr_ph == P_OPC) begin
      for (int t = 0; t < 3; t++) begin
        decode_opcode(o, op, am);
        if (op != OP_NOP || o == 8'hEA) break;
        o = 8'($urandom_range(0, 255));
      end
    end
    return o;
  endfunction

  task automatic finish_sequence();
    while (pr_ph != P_IDLE) issue_cmd(MODE_DATA, next_byte());
  endtask

  task automatic run_instr();
    issue_cmd(MODE_START, 8'($urandom_range(0, 255)));
    finish_sequence();
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == CFG_RESET_FROM_VECTOR) pr_vec_sel = v[0];
    else pr_start = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic core_reset();
    issue_cmd(MODE_RESET, 8'($urandom_range(0, 255)));
    finish_sequence();
  endtask

  // ----------------------------------------------------------------- tests

  task automatic test_reset_paths();
    script_q = '{8'h00, 8'h02};
    core_reset();
    drain();
    write_cfg(CFG_RESET_FROM_VECTOR, 16'h0000);
    write_cfg(CFG_START_ADDRESS, 16'hFFFF);
    core_reset();
    drain();
    write_cfg(CFG_START_ADDRESS, 16'h0400);
    core_reset();
  endtask

  task automatic test_load_extremes();
    script_q = '{8'hA9, 8'hFF}; run_instr();
    script_q = '{8'hA9, 8'h00}; run_instr();
    script_q = '{8'hA2, 8'h80}; run_instr();
    script_q = '{8'hA0, 8'h7F}; run_instr();
  endtask

  // ADC and SBC stay binary with the decimal flag set.
  task automatic test_binary_with_decimal();
    script_q = '{8'hF8}; run_instr();
    script_q = '{8'h38}; run_instr();
    script_q = '{8'h69, 8'h7F}; run_instr();
    script_q = '{8'hE9, 8'hFF}; run_instr();
  endtask

  // Indirect JMP through a pointer at the end of a page.
  task automatic test_jmp_page_wrap();
    script_q = '{8'h6C, 8'hFF, 8'h10, 8'h34, 8'h12}; run_instr();
  endtask

  task automatic test_zero_page_wrap();
    script_q = '{8'hA2, 8'hFF}; run_instr();
    script_q = '{8'hA1, 8'h80, 8'h00, 8'h30, 8'h5A}; run_instr();
    script_q = '{8'hB1, 8'hFF, 8'hF0, 8'h30, 8'hA5}; run_instr();
  endtask

  task automatic test_brk_rti();
    script_q = '{8'h00, 8'h00, 8'h00, 8'h05}; run_instr();
    script_q = '{8'h40, 8'hC3, 8'h02, 8'h04}; run_instr();
  endtask

  task automatic test_jsr_rts();
    script_q = '{8'h20, 8'h00, 8'h80}; run_instr();
    script_q = '{8'h60, 8'hFF, 8'h04}; run_instr();
  endtask

  // Undocumented opcodes act as no-ops, stores do no data read.
  task automatic test_nop_and_store();
    script_q = '{8'h02}; run_instr();
    script_q = '{8'h9E}; run_instr();
    script_q = '{8'h86, 8'h44}; run_instr();
    script_q = '{8'h48}; run_instr();
    script_q = '{8'h68, 8'h80}; run_instr();
  endtask

  task automatic test_ignored_commands();
    issue_cmd(MODE_DATA, 8'hFF);
    issue_cmd(3'd5, 8'h00);
    issue_cmd(3'd6, 8'h55);
    issue_cmd(3'd7, 8'hAA);
    // Start, IRQ and NMI while an instruction is in progress.
    script_q = '{8'hAD};
    issue_cmd(MODE_START, 8'h00);
    issue_cmd(MODE_DATA, next_byte());
    issue_cmd(MODE_START, 8'h00);
    issue_cmd(MODE_IRQ, 8'h00);
    issue_cmd(MODE_NMI, 8'h00);
    finish_sequence();
    // Masked IRQ, then an accepted one, then NMI.
    script_q = '{8'h78}; run_instr();
    issue_cmd(MODE_IRQ, 8'h00);
    script_q = '{8'h58}; run_instr();
    issue_cmd(MODE_IRQ, 8'h00);
    finish_sequence();
    issue_cmd(MODE_NMI, 8'h00);
    finish_sequence();
    // A reset in the middle of an instruction aborts it.
    script_q = '{8'h6D, 8'h12};
    issue_cmd(MODE_START, 8'h00);
    issue_cmd(MODE_DATA, next_byte());
    issue_cmd(MODE_DATA, next_byte());
    core_reset();
  endtask

  task automatic reconfigure(int k);
    drain();
    case (k % 4)
      1: write_cfg(CFG_START_ADDRESS, 16'h0000);
      2: write_cfg(CFG_START_ADDRESS, 16'($urandom_range(0, 65535)));
      3: write_cfg(CFG_RESET_FROM_VECTOR, 16'h0001);
      default: begin
        write_cfg(CFG_RESET_FROM_VECTOR, 16'h0000);
        write_cfg(CFG_START_ADDRESS, 16'hFFFF);
      end
    endcase
    core_reset();
  endtask

  task automatic test_random_traffic();
    int base;
    int r;
    int phase_no;
    base = cmd_count;
    phase_no = 1;
    while (cmd_count - base < CMD_TARGET) begin
      if (cmd_count - base >= phase_no * 110) begin
        reconfigure(phase_no);
        phase_no++;
      end
      if (cmd_count - base > CMD_TARGET - 60) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 84) issue_cmd(MODE_START, 8'($urandom_range(0, 255)));
      else if (r < 89) issue_cmd(MODE_IRQ, 8'($urandom_range(0, 255)));
      else if (r < 93) issue_cmd(MODE_NMI, 8'($urandom_range(0, 255)));
      else if (r < 95) issue_cmd(MODE_RESET, 8'($urandom_range(0, 255)));
      else issue_cmd(r[0] ? MODE_DATA : 3'($urandom_range(5, 7)),
                     8'($urandom_range(0, 255)));
      // Serve the sequence, with a little noise and a rare abort.
      while (pr_ph != P_IDLE) begin
        r = $urandom_range(0, 199);
        if (r < 190) issue_cmd(MODE_DATA, next_byte());
        else if (r < 199) issue_cmd(3'($urandom_range(0, 7) & 3'b011 ^ 3'b000) == MODE_DATA ?
                                    3'($urandom_range(5, 7)) : 3'($urandom_range(0, 3)),
                                    8'($urandom_range(0, 255)));
        else issue_cmd(MODE_RESET, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ------------------------------------------------------------------ main

  initial begin
    errors = 0;
    cmd_count = 0;
    quiet = 1'b0;
    cmd_valid = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = 16'h0000;
    rst = 1'b1;
    pr_vec_sel = RESET_FROM_VECTOR_DEFAULT;
    pr_start = START_ADDRESS_DEFAULT;
    clear_regs();
    pr_pc = pr_start;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_paths();
    test_load_extremes();
    test_binary_with_decimal();
    test_jmp_page_wrap();
    test_zero_page_wrap();
    test_brk_rti();
    test_jsr_rts();
    test_nop_and_store();
    test_ignored_commands();
    drain();
    write_cfg(CFG_RESET_FROM_VECTOR, 16'h0001);
    core_reset();
    test_random_traffic();

    quiet = 1'b1;
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
